// ===== rtl/cdps_pkg.sv =====
// ----------------------------------------------------------------------------
// cdps_pkg: shared definitions for the clock divider pair search
// Widths of the rate words and default divider code widths.
// ----------------------------------------------------------------------------
package cdps_pkg;

    localparam int C_RATE_W        = 32;
    localparam int C_PRE_DIV_BITS  = 3;
    localparam int C_POST_DIV_BITS = 6;

    typedef logic [C_RATE_W-1:0] t_rate;

endpackage

// ===== rtl/cdps_if.sv =====
// ----------------------------------------------------------------------------
// cdps_if: valid/ready channels of the clock divider pair search
// Request word (source and target rate) and result word (divider codes).
// ----------------------------------------------------------------------------
interface cdps_in_if
    import cdps_pkg::*;
    ();
    logic  valid;
    logic  ready;
    t_rate src_rate;
    t_rate target_rate;

    modport source (output valid, output src_rate, output target_rate, input ready);
    modport sink   (input valid, input src_rate, input target_rate, output ready);
endinterface

interface cdps_out_if
    import cdps_pkg::*;
    #(
        parameter int PRE_W  = C_PRE_DIV_BITS,
        parameter int POST_W = C_POST_DIV_BITS
    )
    ();
    logic              valid;
    logic              ready;
    logic [PRE_W-1:0]  pre_divider;
    logic [POST_W-1:0] post_divider;
    t_rate             deviation;

    modport source (output valid, output pre_divider, output post_divider,
                    output deviation, input ready);
    modport sink   (input valid, input pre_divider, input post_divider,
                    input deviation, output ready);
endinterface

// ===== rtl/cdps_div.sv =====
// ----------------------------------------------------------------------------
// cdps_div: restoring divider, one quotient bit per cycle
// Divides a rate word by a narrow nonzero divisor; done pulses one cycle.
// ----------------------------------------------------------------------------
module cdps_div
    import cdps_pkg::*;
    #(
        parameter int DIVISOR_W = C_POST_DIV_BITS + 1
    )
    (
        input  logic                 i_clk,
        input  logic                 i_rst_n,
        input  logic                 i_start,
        input  t_rate                i_dividend,
        input  logic [DIVISOR_W-1:0] i_divisor,
        output logic                 o_busy,
        output logic                 o_done,
        output t_rate                o_quotient
    );

    localparam int CNT_W = $clog2(C_RATE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(C_RATE_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    t_rate                r_quo;

    logic [DIVISOR_W:0]   w_shift;
    logic [DIVISOR_W:0]   w_sub;
    logic                 w_fits;

    // shift in the next dividend bit, subtract where the divisor fits
    assign w_shift = {r_rem, r_quo[C_RATE_W-1]};
    assign w_sub   = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_sub[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[C_RATE_W-2:0], w_fits};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/clock_divider_pair_search_top.sv =====
// ----------------------------------------------------------------------------
// clock_divider_pair_search_top: two-stage clock divider search
// Finds the first pre/post divider pair whose achieved rate lies closest
// to the requested rate, using one shared bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                   handshake
//  i_in     in   src_rate, target_rate                  valid / ready
//  o_out    out  pre_divider, post_divider, deviation   valid / ready
//
//  Each division runs through start, 32 quotient bits and done. A full
//  search tries all 8 x 64 pairs on the shared divider: one division per
//  pre-divider code visited and one per pair tried. An exact match ends
//  the search early.
//  Reset: synchronous, active low; clears the sequencer and output valid.
//  Stalls: the result sits in an output register, so the next word is taken
//  while it waits; a finished search holds until that register is free.
//
module clock_divider_pair_search_top
    import cdps_pkg::*;
    #(
        parameter int PRE_DIV_BITS  = C_PRE_DIV_BITS,
        parameter int POST_DIV_BITS = C_POST_DIV_BITS
    )
    (
        input  logic       i_clk,
        input  logic       i_rst_n,
        cdps_in_if.sink    i_in,
        cdps_out_if.source o_out
    );

    // divisor holds code + 1, so one bit wider than the wider code
    localparam int DIV_W = ((PRE_DIV_BITS > POST_DIV_BITS) ? PRE_DIV_BITS
                                                           : POST_DIV_BITS) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_PRE,
        S_WAIT_PRE,
        S_START_POST,
        S_WAIT_POST,
        S_CMP,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    t_rate                    r_parent, n_parent;
    t_rate                    r_target, n_target;
    t_rate                    r_stage1, n_stage1;
    t_rate                    r_diff, n_diff;
    logic [PRE_DIV_BITS-1:0]  r_pre, n_pre;
    logic [POST_DIV_BITS-1:0] r_post, n_post;
    logic                     r_have_best, n_have_best;
    logic [PRE_DIV_BITS-1:0]  r_best_pre, n_best_pre;
    logic [POST_DIV_BITS-1:0] r_best_post, n_best_post;
    t_rate                    r_best_dev, n_best_dev;
    logic                     r_out_valid, n_out_valid;
    logic [PRE_DIV_BITS-1:0]  r_out_pre, n_out_pre;
    logic [POST_DIV_BITS-1:0] r_out_post, n_out_post;
    t_rate                    r_out_dev, n_out_dev;

    logic                     w_div_start;
    logic                     w_div_busy;
    logic                     w_div_done;
    t_rate                    w_div_quo;
    t_rate                    w_dividend;
    logic [DIV_W-1:0]         w_divisor;
    logic                     w_take;
    t_rate                    w_new_dev;
    logic                     w_out_free;

    // ------------------------------------------------------------------
    // Shared divider: parent / (pre + 1), then stage1 / (post + 1)
    // ------------------------------------------------------------------
    assign w_div_start = (r_state == S_START_PRE) || (r_state == S_START_POST);
    assign w_dividend  = (r_state == S_START_PRE) ? r_parent : r_stage1;
    assign w_divisor   = (r_state == S_START_PRE)
                       ? DIV_W'(r_pre) + DIV_W'(1)
                       : DIV_W'(r_post) + DIV_W'(1);

    cdps_div #(
        .DIVISOR_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // first candidate always wins; later ones only on a strictly smaller gap
    assign w_take     = !r_have_best || (r_diff < r_best_dev);
    assign w_new_dev  = w_take ? r_diff : r_best_dev;
    assign w_out_free = !r_out_valid || o_out.ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_parent    = r_parent;
        n_target    = r_target;
        n_stage1    = r_stage1;
        n_diff      = r_diff;
        n_pre       = r_pre;
        n_post      = r_post;
        n_have_best = r_have_best;
        n_best_pre  = r_best_pre;
        n_best_post = r_best_post;
        n_best_dev  = r_best_dev;
        n_out_pre   = r_out_pre;
        n_out_post  = r_out_post;
        n_out_dev   = r_out_dev;
        // drop the result once the sink takes it
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_parent    = i_in.src_rate;
                    n_target    = i_in.target_rate;
                    n_pre       = '0;
                    n_have_best = 1'b0;
                    n_state     = S_START_PRE;
                end
            end
            S_START_PRE: begin
                n_state = S_WAIT_PRE;
            end
            S_WAIT_PRE: begin
                if (w_div_done) begin
                    n_stage1 = w_div_quo;
                    n_post   = '0;
                    n_state  = S_START_POST;
                end
            end
            S_START_POST: begin
                n_state = S_WAIT_POST;
            end
            S_WAIT_POST: begin
                if (w_div_done) begin
                    n_diff  = (w_div_quo > r_target) ? (w_div_quo - r_target)
                                                     : (r_target - w_div_quo);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_take) begin
                    n_have_best = 1'b1;
                    n_best_pre  = r_pre;
                    n_best_post = r_post;
                    n_best_dev  = r_diff;
                end
                // advance post code, then pre code; stop on an exact match or after the last pair
                priority if (w_new_dev == '0) begin
                    n_state = S_DONE;
                end else if (r_post != '1) begin
                    n_post  = r_post + POST_DIV_BITS'(1);
                    n_state = S_START_POST;
                end else if (r_pre != '1) begin
                    n_pre   = r_pre + PRE_DIV_BITS'(1);
                    n_state = S_START_PRE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pre   = r_best_pre;
                    n_out_post  = r_best_post;
                    n_out_dev   = r_best_dev;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_parent    <= n_parent;
        r_target    <= n_target;
        r_stage1    <= n_stage1;
        r_diff      <= n_diff;
        r_pre       <= n_pre;
        r_post      <= n_post;
        r_have_best <= n_have_best;
        r_best_pre  <= n_best_pre;
        r_best_post <= n_best_post;
        r_best_dev  <= n_best_dev;
        r_out_pre   <= n_out_pre;
        r_out_post  <= n_out_post;
        r_out_dev   <= n_out_dev;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.pre_divider  = r_out_pre;
    assign o_out.post_divider = r_out_post;
    assign o_out.deviation    = r_out_dev;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_done_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT_POST && w_div_done) |=> (r_state == S_CMP))
        else $error("post quotient not compared");

    a_best_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_have_best) |=> (r_best_dev <= $past(r_best_dev)))
        else $error("best deviation grew");

    a_done_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_have_best)
        else $error("search finished without a candidate");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for clock_divider_pair_search_top
// Feeds rate requests (directed corner cases, then mostly reachable targets
// with random content) through the request channel with random gaps, checks
// every returned divider word against an in-bench search over the code pairs.
// ----------------------------------------------------------------------------
module tb;
    import cdps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRE_CODES   = 1 << C_PRE_DIV_BITS;
    localparam int POST_CODES  = 1 << C_POST_DIV_BITS;
    // The limit covers 116 words, each at most a full search, with the
    // longest gaps on both sides.
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct {
        t_rate parent;
        t_rate target;
        bit    hold_for_drain;   // wait for every result before sending
    } t_rate_request;

    typedef struct packed {
        logic [C_PRE_DIV_BITS-1:0]  pre;
        logic [C_POST_DIV_BITS-1:0] post;
        t_rate                      deviation;
    } t_divider_choice;

    bit   i_clk = 1'b0;
    logic i_rst_n;

    cdps_in_if  u_in ();
    cdps_out_if u_out ();

    clock_divider_pair_search_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in.sink),
        .o_out   (u_out.source)
    );

    t_rate_request   request_q[$];
    t_divider_choice choice_q[$];
    int              n_accepted = 0;   // driver side, blocking updates
    int              n_results  = 0;   // monitor side, nonblocking updates
    int              n_errors   = 0;
    int              cycle_count = 0;
    int              send_gap   = 0;
    int              recv_stall = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Walk pre codes outside, post codes inside; keep the first strictly
    // better pair and stop on the first exact hit.
    function automatic t_divider_choice search_dividers(t_rate parent, t_rate target);
        t_divider_choice best;
        t_rate           stage1;
        t_rate           achieved;
        t_rate           gap;
        bit              found;
        bit              done;
        best  = '0;
        found = 1'b0;
        done  = 1'b0;
        for (int pre = 0; pre < PRE_CODES && !done; pre++) begin
            stage1 = parent / t_rate'(pre + 1);
            for (int post = 0; post < POST_CODES && !done; post++) begin
                achieved = stage1 / t_rate'(post + 1);
                gap      = (achieved > target) ? achieved - target : target - achieved;
                if (!found || gap < best.deviation) begin
                    found          = 1'b1;
                    best.pre       = pre[C_PRE_DIV_BITS-1:0];
                    best.post      = post[C_POST_DIV_BITS-1:0];
                    best.deviation = gap;
                end
                if (best.deviation == '0) begin
                    done = 1'b1;
                end
            end
        end
        return best;
    endfunction

    // Mostly short gaps, a few long ones; one window in eight runs flat out.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (cycle_count[15:13] == 3'd0 || roll < 35) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 300);
    endfunction

    task automatic add_request(t_rate parent, t_rate target, bit hold);
        t_rate_request req;
        req.parent         = parent;
        req.target         = target;
        req.hold_for_drain = hold;
        request_q.push_back(req);
    endtask

    // Request driver: hold the word while stalled, advance on acceptance,
    // insert a random gap after each accepted word.
    always @(posedge i_clk) begin
        t_rate_request req;
        if (!i_rst_n) begin
            u_in.valid <= 1'b0;
            send_gap   = 0;
        end else begin
            if (u_in.valid && u_in.ready) begin
                n_accepted++;
                send_gap = pick_gap();
            end
            if (!u_in.valid || u_in.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    u_in.valid <= 1'b0;
                end else if (request_q.size() > 0 &&
                             !(request_q[0].hold_for_drain && n_results != n_accepted)) begin
                    req = request_q.pop_front();
                    u_in.src_rate    <= req.parent;
                    u_in.target_rate <= req.target;
                    u_in.valid       <= 1'b1;
                end else begin
                    u_in.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on every accepted request, check every accepted
    // result against the oldest prediction, and stall the result channel.
    always @(posedge i_clk) begin
        t_divider_choice want;
        if (!i_rst_n) begin
            u_out.ready <= 1'b0;
            recv_stall  = 0;
        end else begin
            if (u_in.valid && u_in.ready) begin
                choice_q.push_back(search_dividers(u_in.src_rate, u_in.target_rate));
            end
            if (u_out.valid && u_out.ready) begin
                n_results <= n_results + 1;
                if (choice_q.size() == 0) begin
                    $error("result word with no request pending: pre %0d post %0d dev %0d",
                           u_out.pre_divider, u_out.post_divider, u_out.deviation);
                    n_errors++;
                end else begin
                    want = choice_q.pop_front();
                    if (u_out.pre_divider !== want.pre) begin
                        $error("pre_divider: expected %0d, got %0d", want.pre,
                               u_out.pre_divider);
                        n_errors++;
                    end
                    if (u_out.post_divider !== want.post) begin
                        $error("post_divider: expected %0d, got %0d", want.post,
                               u_out.post_divider);
                        n_errors++;
                    end
                    if (u_out.deviation !== want.deviation) begin
                        $error("deviation: expected %0d, got %0d", want.deviation,
                               u_out.deviation);
                        n_errors++;
                    end
                end
                recv_stall = pick_gap();
            end
            if (recv_stall > 0) begin
                recv_stall--;
                u_out.ready <= 1'b0;
            end else begin
                u_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: drop the run if the search never finishes.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_rate parent;
        t_rate target;
        t_rate exact;
        int    kind;
        int    pre_pick;
        int    post_pick;

        // Known levels on every block input before the first edge.
        i_rst_n           = 1'b0;
        u_in.valid        = 1'b0;
        u_in.src_rate     = '0;
        u_in.target_rate  = '0;
        u_out.ready       = 1'b0;

        // Directed part: zero parent, zero target, extremes, ties, late hits.
        add_request(32'd0,          32'd0,          1'b0);
        add_request(32'd0,          32'hFFFF_FFFF,  1'b0);  // deviation is the target
        add_request(32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);  // exact on first pair
        add_request(32'hFFFF_FFFF,  32'd0,          1'b0);  // slowest pair wins
        add_request(32'hFFFF_FFFF,  32'd1,          1'b0);
        add_request(32'd1,          32'd0,          1'b1);  // zero reached on second post code
        add_request(32'd100,        32'd45,         1'b0);  // equal distances, first kept
        add_request(32'd512000,     32'd1000,       1'b0);  // hit only at the last pair
        add_request(32'hFFFF_FFFF,  32'h8000_0000,  1'b0);
        add_request(32'd1000,       32'd5000,       1'b0);  // target above every rate
        add_request(32'hAAAA_AAAA,  32'h5555_5555,  1'b0);
        add_request(32'h5555_5555,  32'hAAAA_AAAA,  1'b0);
        add_request(32'h8000_0000,  32'h0100_0000,  1'b0);
        add_request(32'd24_000_000, 32'd48_000,     1'b1);
        add_request(32'd7,          32'd1,          1'b0);
        add_request(32'd64,         32'd3,          1'b0);

        // Random part: mostly reachable targets so the search stops at
        // varied pairs, some near misses, some noise.
        for (int i = 0; i < 100; i++) begin
            kind      = $urandom_range(0, 19);
            pre_pick  = $urandom_range(0, PRE_CODES - 1);
            post_pick = $urandom_range(0, POST_CODES - 1);
            parent    = ($urandom_range(0, 3) == 0) ? t_rate'($urandom_range(0, 5000))
                                                    : t_rate'($urandom);
            exact     = parent / t_rate'(pre_pick + 1) / t_rate'(post_pick + 1);
            if (kind < 11) begin
                target = exact;
            end else if (kind < 16) begin
                target = exact + t_rate'($urandom_range(0, 8)) - t_rate'(4);
            end else begin
                target = $urandom;
            end
            add_request(parent, target, (i % 40) == 39);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge so the driver and monitor have settled.
        while (request_q.size() != 0 || u_in.valid) begin
            @(negedge i_clk);
        end
        while (n_results != n_accepted) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (choice_q.size() != 0) begin
            $error("%0d result words never arrived", choice_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdps_pkg.sv
rtl/cdps_if.sv
rtl/cdps_div.sv
rtl/clock_divider_pair_search_top.sv
bench/tb.sv
